// ===== design/stsr_pkg.sv =====
// stsr_pkg: shared constants, types and helpers of the stencil RHS block.
// Used by stsr_ctrl, stsr_dp and shock_transport_stencil_rhs_top.
package stsr_pkg;

    localparam int SPACE_CELLS = 256;
    localparam int MOM_CELLS   = 32;
    localparam int X_W         = $clog2(SPACE_CELLS);
    localparam int P_W         = $clog2(MOM_CELLS);
    localparam int ADDR_W      = $clog2(2 * MOM_CELLS);
    localparam int CMP_W       = (X_W > 8) ? X_W : 8;
    localparam int ACC_W       = 56;
    localparam int FL_W        = 48;
    localparam int DIV_W       = 52;
    // divide-by-3 pipe: split/high multiply, then low reciprocal multiply
    localparam int DIV_STEPS   = 2;
    localparam int STEP_W      = 4;

    localparam logic [2:0] REG_SHOCK_INDEX   = 3'd0;
    localparam logic [2:0] REG_SOURCE_X      = 3'd1;
    localparam logic [2:0] REG_SOURCE_STR    = 3'd2;
    localparam logic [2:0] REG_DIFF_GAIN     = 3'd3;
    localparam logic [2:0] REG_ADV_UP        = 3'd4;
    localparam logic [2:0] REG_ADV_DOWN      = 3'd5;
    localparam logic [2:0] REG_SHOCK_DIV     = 3'd6;
    localparam logic [2:0] REG_MOM_GAIN      = 3'd7;

    // multiply / accumulate operations, issued in this order
    typedef enum logic [3:0] {
        OP_DC  = 4'd0,
        OP_DXM = 4'd1,
        OP_DXP = 4'd2,
        OP_VXM = 4'd3,
        OP_VXP = 4'd4,
        OP_SC  = 4'd5,
        OP_GPP = 4'd6,
        OP_GPM = 4'd7,
        OP_SM  = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        RD_C  = 2'd0,
        RD_XM = 2'd1,
        RD_PM = 2'd2,
        RD_PP = 2'd3
    } t_rd;

    typedef struct packed {
        logic accept;
        logic rd_en;
        t_rd  rd_sel;
        logic cap_en;
        t_rd  cap_sel;
        logic wr_en;
        logic init;
        logic mul_en;
        t_op  mul_op;
        logic acc_en;
        t_op  acc_op;
        logic div_load;
        logic div_step;
        logic div_fin;
        logic load_a;
        logic load_b;
    } t_cmd;

    typedef struct packed {
        logic has_a;
        logic has_b;
        logic edge_a;
        logic out_free;
    } t_status;

    function automatic logic [ADDR_W-1:0] slot(input logic x0, input logic [P_W-1:0] p);
        logic [ADDR_W-1:0] base;
        base = x0 ? ADDR_W'(MOM_CELLS) : '0;
        return base + ADDR_W'(p);
    endfunction

    function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] a);
        logic [32:0] r;
        if (a > ACC_W'(64'sh7FFF_FFFF)) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (a < -ACC_W'(64'sh8000_0000)) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, a[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/stsr_ctrl.sv =====
// stsr_ctrl: sequencer of the stencil RHS block (read, multiply, divide, emit).
// Depends on stsr_pkg; drives stsr_dp through t_cmd, reads t_status.
module stsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  stsr_pkg::t_status i_status,
    output stsr_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_OUT_A = 7'b0100000,
        S_OUT_B = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [stsr_pkg::STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                    n_step       = '0;
                end
            end
            S_READ: begin
                // step 0..3 issue reads, 1..4 capture the registered data
                o_cmd.rd_en   = (r_step < 4'd4);
                o_cmd.rd_sel  = stsr_pkg::t_rd'(r_step[1:0]);
                o_cmd.cap_en  = (r_step != 4'd0);
                o_cmd.cap_sel = stsr_pkg::t_rd'(r_step[1:0] - 2'd1);
                if (r_step == 4'd4) begin
                    o_cmd.wr_en = 1'b1;
                    n_step      = '0;
                    if (!i_status.has_a) begin
                        n_state = i_status.has_b ? S_OUT_B : S_IDLE;
                    end else if (i_status.edge_a) begin
                        n_state = S_OUT_A;
                    end else begin
                        n_state = S_MUL;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_MUL: begin
                o_cmd.init   = (r_step == 4'd0);
                o_cmd.mul_en = (r_step <= 4'd7) || (r_step == 4'd9);
                o_cmd.mul_op = (r_step == 4'd9) ? stsr_pkg::OP_SM : stsr_pkg::t_op'(r_step);
                o_cmd.acc_en = (r_step >= 4'd1) && (r_step <= 4'd8);
                o_cmd.acc_op = stsr_pkg::t_op'(r_step - 4'd1);
                if (r_step == 4'd10) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                    n_step         = '0;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == 4'(stsr_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_OUT_A;
            end
            S_OUT_A: begin
                if (i_status.out_free) begin
                    o_cmd.load_a = 1'b1;
                    n_state      = i_status.has_b ? S_OUT_B : S_IDLE;
                end
            end
            S_OUT_B: begin
                if (i_status.out_free) begin
                    o_cmd.load_b = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("controller state not one-hot");
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_READ))
        else $error("accepted word did not start a read pass");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < 4'(stsr_pkg::DIV_STEPS)))
        else $error("divider step count out of range");
    a_fin_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_DIV))
        else $error("final accumulate without divide");

endmodule

// ===== design/stsr_dp.sv =====
// stsr_dp: datapath of the stencil RHS block: config registers, row buffer,
// shared multiplier, accumulators, divide-by-3 unit and output register. Uses stsr_pkg.
module stsr_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_data,
    input  logic [31:0]       i_density,
    input  stsr_pkg::t_cmd    i_cmd,
    output stsr_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [47:0]       o_out_data,
    output logic              o_out_user
);

    // configuration
    logic [7:0]         r_shock_index, r_source_x;
    logic signed [31:0] r_source_str, r_diff_gain, r_adv_up, r_adv_down;
    logic signed [31:0] r_shock_div, r_mom_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shock_index <= 8'd128;
            r_source_x    <= 8'd128;
            r_source_str  <= 32'sd65536;
            r_diff_gain   <= 32'sd426147840;
            r_adv_up      <= 32'sd8355840;
            r_adv_down    <= 32'sd2088960;
            r_shock_div   <= -32'sd6266880;
            r_mom_gain    <= 32'sd254935;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                stsr_pkg::REG_SHOCK_INDEX: r_shock_index <= i_cfg_data[7:0];
                stsr_pkg::REG_SOURCE_X:    r_source_x    <= i_cfg_data[7:0];
                stsr_pkg::REG_SOURCE_STR:  r_source_str  <= i_cfg_data;
                stsr_pkg::REG_DIFF_GAIN:   r_diff_gain   <= i_cfg_data;
                stsr_pkg::REG_ADV_UP:      r_adv_up      <= i_cfg_data;
                stsr_pkg::REG_ADV_DOWN:    r_adv_down    <= i_cfg_data;
                stsr_pkg::REG_SHOCK_DIV:   r_shock_div   <= i_cfg_data;
                stsr_pkg::REG_MOM_GAIN:    r_mom_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // raster position: r_sx/r_sp next sample, r_x/r_p current word
    logic [stsr_pkg::X_W-1:0] r_sx, r_x, cx;
    logic [stsr_pkg::P_W-1:0] r_sp, r_p;
    logic signed [31:0]       r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sp <= '0;
        end else if (i_cmd.accept) begin
            if (r_sp == stsr_pkg::P_W'(stsr_pkg::MOM_CELLS - 1)) begin
                r_sp <= '0;
                r_sx <= (r_sx == stsr_pkg::X_W'(stsr_pkg::SPACE_CELLS - 1)) ? '0 : r_sx + 1'b1;
            end else begin
                r_sp <= r_sp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= r_sx;
            r_p <= r_sp;
            r_d <= i_density;
        end
    end

    assign cx = r_x - 1'b1;

    // row buffer, two rows by parity of the space index
    logic [31:0] mem [2*stsr_pkg::MOM_CELLS];
    logic [31:0] r_rd_data;
    logic [stsr_pkg::ADDR_W-1:0] rd_addr;

    always_comb begin
        case (i_cmd.rd_sel)
            stsr_pkg::RD_C:  rd_addr = stsr_pkg::slot(cx[0], r_p);
            stsr_pkg::RD_XM: rd_addr = stsr_pkg::slot(r_x[0], r_p);
            stsr_pkg::RD_PM: rd_addr = stsr_pkg::slot(cx[0], r_p - 1'b1);
            stsr_pkg::RD_PP: rd_addr = stsr_pkg::slot(cx[0], r_p + 1'b1);
            default:         rd_addr = stsr_pkg::slot(cx[0], r_p);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.wr_en) begin
            mem[stsr_pkg::slot(r_x[0], r_p)] <= r_d;
        end
    end

    logic signed [31:0] r_c, r_xm, r_pm, r_pp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                stsr_pkg::RD_C:  r_c  <= r_rd_data;
                stsr_pkg::RD_XM: r_xm <= r_rd_data;
                stsr_pkg::RD_PM: r_pm <= r_rd_data;
                stsr_pkg::RD_PP: r_pp <= r_rd_data;
                default: ;
            endcase
        end
    end

    // cell-dependent coefficients
    logic [stsr_pkg::CMP_W-1:0] cx_w, sh_w, srcx_w;
    logic                       near, src_hit;
    logic signed [31:0]         coef_v, coef_s;

    assign cx_w    = stsr_pkg::CMP_W'(cx);
    assign sh_w    = stsr_pkg::CMP_W'(r_shock_index);
    assign srcx_w  = stsr_pkg::CMP_W'(r_source_x);
    assign near    = (cx_w == sh_w) || ((sh_w != '0) && (cx_w == sh_w - 1'b1));
    assign coef_s  = near ? r_shock_div : 32'sd0;
    assign coef_v  = (cx_w < sh_w) ? r_adv_up : r_adv_down;
    assign src_hit = (cx_w == srcx_w) && (r_p == stsr_pkg::P_W'(2));

    // shared multiplier
    logic signed [stsr_pkg::ACC_W-1:0] r_sum, r_m;
    logic [32:0]                       m_sat, sum_sat;
    logic signed [31:0]                mul_a, mul_b;
    logic signed [63:0]                r_prod;
    logic signed [stsr_pkg::FL_W-1:0]  fl;
    logic signed [stsr_pkg::ACC_W-1:0] fl_x;

    assign m_sat   = stsr_pkg::sat32(r_m);
    assign sum_sat = stsr_pkg::sat32(r_sum);

    always_comb begin
        case (i_cmd.mul_op)
            stsr_pkg::OP_DC:  begin mul_a = r_diff_gain; mul_b = r_c;  end
            stsr_pkg::OP_DXM: begin mul_a = r_diff_gain; mul_b = r_xm; end
            stsr_pkg::OP_DXP: begin mul_a = r_diff_gain; mul_b = r_d;  end
            stsr_pkg::OP_VXM: begin mul_a = coef_v;      mul_b = r_xm; end
            stsr_pkg::OP_VXP: begin mul_a = coef_v;      mul_b = r_d;  end
            stsr_pkg::OP_SC:  begin mul_a = coef_s;      mul_b = r_c;  end
            stsr_pkg::OP_GPP: begin mul_a = r_mom_gain;  mul_b = r_pp; end
            stsr_pkg::OP_GPM: begin mul_a = r_mom_gain;  mul_b = r_pm; end
            stsr_pkg::OP_SM:  begin mul_a = coef_s;      mul_b = m_sat[31:0]; end
            default:          begin mul_a = '0;          mul_b = '0;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // floor to Q16.16
    assign fl   = r_prod[63:16];
    assign fl_x = stsr_pkg::ACC_W'(fl);

    // floor divide by 3: bias by 3*2^47 to stay non-negative, then
    // N = H*2^26 + L gives N/3 = H*(2^26-1)/3 + floor((H+L)/3)
    localparam logic [stsr_pkg::DIV_W-1:0] DIV_BIAS = stsr_pkg::DIV_W'(3) << 47;
    localparam logic [24:0] THIRD_HI = 25'd22369621;   // (2^26 - 1) / 3
    localparam logic [31:0] THIRD_LO = 32'hAAAA_AAAB;  // ceil(2^33 / 3)
    logic [stsr_pkg::DIV_W-1:0]        r_num;
    logic [50:0]                       r_hq;
    logic [26:0]                       r_hl;
    logic [25:0]                       r_lq;
    logic [58:0]                       lo_prod;
    logic signed [stsr_pkg::ACC_W-1:0] quo_term;

    assign lo_prod = r_hl * THIRD_LO;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num <= stsr_pkg::DIV_W'(fl) + DIV_BIAS;
        end
        if (i_cmd.div_step) begin
            r_hq <= r_num[stsr_pkg::DIV_W-1:26] * THIRD_HI;
            r_hl <= {1'b0, r_num[stsr_pkg::DIV_W-1:26]} + {1'b0, r_num[25:0]};
            r_lq <= lo_prod[58:33];
        end
    end

    assign quo_term = stsr_pkg::ACC_W'(r_hq) + stsr_pkg::ACC_W'(r_lq)
                    - (stsr_pkg::ACC_W'(1) << 47);

    // accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_sum <= src_hit ? stsr_pkg::ACC_W'(r_source_str) : '0;
            r_m   <= stsr_pkg::ACC_W'(r_pm);
        end else if (i_cmd.acc_en) begin
            case (i_cmd.acc_op)
                stsr_pkg::OP_DC:  r_sum <= r_sum - (fl_x <<< 1);
                stsr_pkg::OP_DXM: r_sum <= r_sum + fl_x;
                stsr_pkg::OP_DXP: r_sum <= r_sum + fl_x;
                stsr_pkg::OP_VXM: r_sum <= r_sum + fl_x;
                stsr_pkg::OP_VXP: r_sum <= r_sum - fl_x;
                stsr_pkg::OP_SC:  r_sum <= r_sum - fl_x;
                stsr_pkg::OP_GPP: r_m   <= r_m + fl_x;
                stsr_pkg::OP_GPM: r_m   <= r_m - fl_x;
                default: ;
            endcase
        end else if (i_cmd.div_fin) begin
            r_sum <= r_sum + quo_term;
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_a || i_cmd.load_b) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            o_out_data <= {3'b000, 5'(r_p), 8'(cx),
                           o_status.edge_a ? r_c : sum_sat[31:0]};
            o_out_user <= o_status.edge_a ? 1'b0 : sum_sat[32];
        end else if (i_cmd.load_b) begin
            o_out_data <= {3'b000, 5'(r_p), 8'(r_x), r_d};
            o_out_user <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.has_a    = (r_x != '0);
    assign o_status.has_b    = (r_x == stsr_pkg::X_W'(stsr_pkg::SPACE_CELLS - 1));
    assign o_status.edge_a   = (cx == '0) || (r_p == '0) ||
                               (r_p == stsr_pkg::P_W'(stsr_pkg::MOM_CELLS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(i_cmd.load_a || i_cmd.load_b))
        else $error("output word overwritten while stalled");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_a || i_cmd.load_b) |=> r_out_valid)
        else $error("loaded word not shown");
    a_edge_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_a && o_status.edge_a) |=> !o_out_user)
        else $error("edge cell flagged saturated");

endmodule

// ===== design/shock_transport_stencil_rhs_top.sv =====
// shock_transport_stencil_rhs_top: top level of the stencil RHS block.
// Depends on stsr_pkg, stsr_ctrl and stsr_dp.
//
// Takes a density grid (256 space x 32 momentum cells, Q16.16) in raster
// order, momentum index fastest, one 32-bit word per handshake. The word at
// (x,p) with x >= 1 releases cell (x-1,p); on the last row it also releases
// (x,p) as a pass-through, so results leave in raster order, zero to two per
// input word. Interior cells get source, compression, advection, diffusion
// and momentum terms, summed exactly and saturated (tuser flags saturation);
// edge cells pass through. An interior cell is accepted, then gets four
// row-buffer reads and the write-back, nine products on the one shared 32x32
// multiplier, the two steps of the pipelined divide-by-3 unit, one final
// accumulate and one output load. Edge cells skip the multiply and divide,
// row-0 words also skip the output load, and the last row adds a load for
// its pass-through word. A stalled output adds its stall to the next load.
// The input is taken only between words; a result waiting in the output
// register does not block the next input. Registers are written at any
// edge with i_cfg_we high; the user must write them only while idle, as the
// block does not enforce it. The row buffer needs no clearing.
module shock_transport_stencil_rhs_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port, index per register list (0..7)
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] density
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] rhs_value, [39:32] space_index,
                                          // [44:40] momentum_index, [47:45] zero
    output logic        o_m_axis_tuser    // [0] overflow
);

    stsr_pkg::t_cmd    cmd;
    stsr_pkg::t_status status;

    stsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_density   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule
